FILE: hw/rtl/hrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types and constants of the HTTP request header parser: header ids,
// byte kinds, character codes and the header name table.
// ----------------------------------------------------------------------------
package hrp_pkg;

  localparam int unsigned NUM_HDRS     = 9;
  localparam int unsigned HDR_MAX_LEN  = 17;
  localparam int unsigned HDR_BITS     = HDR_MAX_LEN * 8;

  typedef logic [NUM_HDRS-1:0] hdr_mask_t;

  // Header ids.
  localparam logic [3:0] ID_CLEN  = 4'd8;
  localparam logic [3:0] ID_OTHER = 4'd9;

  localparam hdr_mask_t ALL_NAMES = 9'h1FF;
  localparam hdr_mask_t GET_ONLY  = 9'h038;
  localparam hdr_mask_t PUT_ONLY  = 9'h1C0;

  // Byte kinds.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_URL   = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_GET_MASK = 1'b0;
  localparam logic CFG_PUT_MASK = 1'b1;

  localparam hdr_mask_t GET_MASK_RST = 9'd63;
  localparam hdr_mask_t PUT_MASK_RST = 9'd199;

  // Character codes.
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [23:0] VERB_GET   = "GET";
  localparam logic [23:0] VERB_PUT   = "PUT";
  localparam logic [63:0] PROTO_TEXT = "HTTP/1.1";

  // Names are right-aligned in each entry: the last character sits in bits [7:0].
  localparam logic [HDR_BITS-1:0] HDR_NAME [NUM_HDRS] = '{
    HDR_BITS'("Host"),
    HDR_BITS'("Connection"),
    HDR_BITS'("Date"),
    HDR_BITS'("Accept"),
    HDR_BITS'("Accept-Language"),
    HDR_BITS'("If-Modified-Since"),
    HDR_BITS'("Content-Language"),
    HDR_BITS'("Content-Type"),
    HDR_BITS'("Content-Length")
  };

  localparam logic [4:0] HDR_LEN [NUM_HDRS] = '{
    5'd4, 5'd10, 5'd4, 5'd6, 5'd15, 5'd17, 5'd16, 5'd12, 5'd14
  };

endpackage

FILE: hw/rtl/hrp_name_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_name_match
// Header name matcher: one compare lane per known header narrows the set of
// live candidates by one character, and the resolver picks the header id
// once the colon arrives.
// ----------------------------------------------------------------------------
module hrp_name_match (
  input  logic [7:0]         byte_i,
  input  logic [4:0]         mpos_i,
  input  hrp_pkg::hdr_mask_t cand_i,
  input  logic               put_i,
  output hrp_pkg::hdr_mask_t cand_o,
  output logic [3:0]         hdr_id_o
);

  hrp_pkg::hdr_mask_t len_hit;
  hrp_pkg::hdr_mask_t allow;
  hrp_pkg::hdr_mask_t elig;

  for (genvar g = 0; g < hrp_pkg::NUM_HDRS; g++) begin : g_lane
    logic [4:0] ofs;
    logic [7:0] ch;

    // Offset of the character at mpos from the right end of the entry.
    assign ofs = hrp_pkg::HDR_LEN[g] - 5'd1 - mpos_i;
    assign ch  = 8'(hrp_pkg::HDR_NAME[g] >> {ofs, 3'b000});

    assign cand_o[g]  = cand_i[g] && (mpos_i < hrp_pkg::HDR_LEN[g]) && (ch == byte_i);
    assign len_hit[g] = (mpos_i == hrp_pkg::HDR_LEN[g]);
  end

  // Method-specific names only count for their own method.
  assign allow = put_i ? (hrp_pkg::ALL_NAMES & ~hrp_pkg::GET_ONLY)
                       : (hrp_pkg::ALL_NAMES & ~hrp_pkg::PUT_ONLY);
  assign elig  = cand_i & allow & len_hit;

  always_comb begin
    hdr_id_o = hrp_pkg::ID_OTHER;
    for (int i = hrp_pkg::NUM_HDRS - 1; i >= 0; i--) begin
      if (elig[i]) begin
        hdr_id_o = 4'(i);
      end
    end
  end

endmodule

FILE: hw/rtl/http_request_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_header_parser
// Parses an HTTP/1.1 GET or PUT request one byte per beat, tags URL and
// header value bytes, builds the Content-Length value and reports a verdict
// at the blank line or at the last byte of the buffer.
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_ready_o  request_byte_i, final_byte_i
//   out      source     out_valid_o / out_ready_i
//            byte_kind_o, header_id_o, data_byte_o, request_done_o,
//            request_valid_o, method_put_o, body_length_o
//   cfg      sink       cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One beat is accepted per cycle while the output is not stalled. Each beat
// goes through an input register and a result register; the parse state
// updates as a beat moves from the input register to the result register.
// A stall on the output holds both registers; the input stays ready while
// either register can move. Reset empties both stages and returns the parse
// state and the required masks to their defaults.
// ----------------------------------------------------------------------------
module http_request_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  request_byte_i,
  input  logic        final_byte_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  byte_kind_o,
  output logic [3:0]  header_id_o,
  output logic [7:0]  data_byte_o,
  output logic        request_done_o,
  output logic        request_valid_o,
  output logic        method_put_o,
  output logic [31:0] body_length_o,

  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_data_i
);

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_URL,
    PH_VERSION,
    PH_NAME,
    PH_SPACE,
    PH_VALUE,
    PH_LF,
    PH_ERROR
  } phase_e;

  // Configuration.
  hrp_pkg::hdr_mask_t get_mask_q, put_mask_q;

  // Input stage.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_final_q;

  // Parse state.
  phase_e             phase_q, phase_d;
  logic [4:0]         mpos_q, mpos_d;
  hrp_pkg::hdr_mask_t cand_q, cand_d;
  logic [3:0]         cur_q, cur_d;
  hrp_pkg::hdr_mask_t pres_q, pres_d;
  logic               put_q, put_d;
  logic [31:0]        len_q, len_d;
  logic [1:0]         track_q, track_d;
  logic               err_q, err_d;

  // Result of the current beat.
  logic [1:0] kind;
  logic [3:0] hid;
  logic       done;
  logic       verdict;

  logic fire;

  hrp_pkg::hdr_mask_t name_cand;
  logic [3:0]         name_id;
  hrp_pkg::hdr_mask_t cur_bit;
  hrp_pkg::hdr_mask_t need;
  logic               mask_ok;
  logic [7:0]         verb_get_ch, verb_put_ch, proto_ch;
  logic               c0, c1;
  logic [35:0]        len_ext, len_next;
  logic [7:0]         c;

  assign c    = s1_byte_q;
  assign fire = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || fire;

  hrp_name_match u_name_match (
    .byte_i   (c),
    .mpos_i   (mpos_q),
    .cand_i   (cand_q),
    .put_i    (put_q),
    .cand_o   (name_cand),
    .hdr_id_o (name_id)
  );

  assign verb_get_ch = 8'(hrp_pkg::VERB_GET >> {2'd2 - mpos_q[1:0], 3'b000});
  assign verb_put_ch = 8'(hrp_pkg::VERB_PUT >> {2'd2 - mpos_q[1:0], 3'b000});
  assign proto_ch    = 8'(hrp_pkg::PROTO_TEXT >> {3'd7 - mpos_q[2:0], 3'b000});

  // Ids above the table shift the one out of range and give an empty mask.
  assign cur_bit = hrp_pkg::hdr_mask_t'(1) << cur_q;

  // Content-Length step: len * 10 + digit, saturating at the 32-bit maximum.
  assign len_ext  = {4'd0, len_q};
  assign len_next = (len_ext << 3) + (len_ext << 1) + 36'(c - hrp_pkg::CH_ZERO);

  assign need    = put_d ? put_mask_q : get_mask_q;
  assign mask_ok = ((pres_d & need) == need);

  always_comb begin
    phase_d = phase_q;
    mpos_d  = mpos_q;
    cand_d  = cand_q;
    cur_d   = cur_q;
    pres_d  = pres_q;
    put_d   = put_q;
    len_d   = len_q;
    err_d   = err_q;
    kind    = hrp_pkg::KIND_NONE;
    hid     = hrp_pkg::ID_OTHER;
    done    = 1'b0;
    verdict = 1'b0;
    c0      = cand_q[0] && (c == verb_get_ch);
    c1      = cand_q[1] && (c == verb_put_ch);

    // Progress through CR LF CR LF.
    if (c == hrp_pkg::CH_CR) begin
      track_d = (track_q == 2'd2) ? 2'd3 : 2'd1;
    end else if (c == hrp_pkg::CH_LF) begin
      track_d = (track_q == 2'd1) ? 2'd2 : 2'd0;
    end else begin
      track_d = 2'd0;
    end

    unique case (phase_q)
      PH_METHOD: begin
        if (c == hrp_pkg::CH_SP) begin
          if (mpos_q == 5'd3 && (cand_q[1:0] != 2'b00)) begin
            put_d   = cand_q[1];
            cand_d  = hrp_pkg::ALL_NAMES;
            mpos_d  = 5'd0;
            phase_d = PH_URL;
          end else begin
            err_d   = 1'b1;
            phase_d = PH_ERROR;
          end
        end else if (mpos_q >= 5'd3) begin
          err_d   = 1'b1;
          phase_d = PH_ERROR;
        end else begin
          cand_d = {cand_q[8:2], c1, c0};
          if (!c0 && !c1) begin
            err_d   = 1'b1;
            phase_d = PH_ERROR;
          end else begin
            mpos_d = mpos_q + 5'd1;
          end
        end
      end
      PH_URL: begin
        if (c == hrp_pkg::CH_SP) begin
          mpos_d  = 5'd0;
          phase_d = PH_VERSION;
        end else if (c == hrp_pkg::CH_CR || c == hrp_pkg::CH_LF) begin
          err_d   = 1'b1;
          phase_d = PH_ERROR;
        end else begin
          kind = hrp_pkg::KIND_URL;
        end
      end
      PH_VERSION: begin
        if (mpos_q < 5'd8) begin
          if (c == proto_ch) begin
            mpos_d = mpos_q + 5'd1;
          end else begin
            err_d   = 1'b1;
            phase_d = PH_ERROR;
          end
        end else if (c == hrp_pkg::CH_CR) begin
          phase_d = PH_LF;
        end else begin
          err_d   = 1'b1;
          phase_d = PH_ERROR;
        end
      end
      PH_NAME: begin
        if (mpos_q == 5'd0 && c == hrp_pkg::CH_CR) begin
          phase_d = PH_LF;
        end else if (c == hrp_pkg::CH_COLON) begin
          cur_d   = name_id;
          phase_d = PH_SPACE;
        end else if (c == hrp_pkg::CH_CR || c == hrp_pkg::CH_LF) begin
          err_d   = 1'b1;
          phase_d = PH_ERROR;
        end else begin
          cand_d = name_cand;
          if (mpos_q != 5'd31) begin
            mpos_d = mpos_q + 5'd1;
          end
        end
      end
      PH_SPACE: begin
        if (c == hrp_pkg::CH_SP) begin
          // A repeated header starts over: the last one counts.
          pres_d = pres_q & ~cur_bit;
          if (cur_q == hrp_pkg::ID_CLEN) begin
            len_d = 32'd0;
          end
          mpos_d  = 5'd0;
          phase_d = PH_VALUE;
        end else begin
          err_d   = 1'b1;
          phase_d = PH_ERROR;
        end
      end
      PH_VALUE: begin
        if (c == hrp_pkg::CH_CR) begin
          phase_d = PH_LF;
        end else if (c == hrp_pkg::CH_LF) begin
          err_d   = 1'b1;
          phase_d = PH_ERROR;
        end else begin
          kind   = hrp_pkg::KIND_VALUE;
          hid    = cur_q;
          pres_d = pres_q | cur_bit;
          // In a value, mpos marks that the leading digit run has ended.
          if (cur_q == hrp_pkg::ID_CLEN && mpos_q == 5'd0) begin
            if (c >= hrp_pkg::CH_ZERO && c <= hrp_pkg::CH_NINE) begin
              len_d = (len_next[35:32] != 4'd0) ? 32'hFFFF_FFFF : len_next[31:0];
            end else begin
              mpos_d = 5'd1;
            end
          end
        end
      end
      PH_LF: begin
        if (c == hrp_pkg::CH_LF) begin
          if (track_q == 2'd3) begin
            done    = 1'b1;
            verdict = !err_q && mask_ok;
          end else begin
            mpos_d  = 5'd0;
            cand_d  = hrp_pkg::ALL_NAMES;
            cur_d   = hrp_pkg::ID_OTHER;
            phase_d = PH_NAME;
          end
        end else begin
          err_d   = 1'b1;
          phase_d = PH_ERROR;
        end
      end
      PH_ERROR: begin
        if (c == hrp_pkg::CH_LF && track_q == 2'd3) begin
          done = 1'b1;
        end
      end
      default: begin
        err_d   = 1'b1;
        phase_d = PH_ERROR;
      end
    endcase

    // The last byte of the buffer ends the request if nothing else did.
    if (s1_final_q && !done) begin
      done    = 1'b1;
      verdict = !err_d && mask_ok &&
                (phase_d == PH_NAME || phase_d == PH_SPACE ||
                 phase_d == PH_VALUE || phase_d == PH_LF);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      get_mask_q  <= hrp_pkg::GET_MASK_RST;
      put_mask_q  <= hrp_pkg::PUT_MASK_RST;
      s1_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
      phase_q     <= PH_METHOD;
      mpos_q      <= 5'd0;
      cand_q      <= hrp_pkg::ALL_NAMES;
      cur_q       <= hrp_pkg::ID_OTHER;
      pres_q      <= '0;
      put_q       <= 1'b0;
      len_q       <= 32'd0;
      track_q     <= 2'd0;
      err_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          hrp_pkg::CFG_GET_MASK: get_mask_q <= cfg_data_i;
          hrp_pkg::CFG_PUT_MASK: put_mask_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end

      if (fire) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end

      if (fire) begin
        if (done) begin
          phase_q <= PH_METHOD;
          mpos_q  <= 5'd0;
          cand_q  <= hrp_pkg::ALL_NAMES;
          cur_q   <= hrp_pkg::ID_OTHER;
          pres_q  <= '0;
          put_q   <= 1'b0;
          len_q   <= 32'd0;
          track_q <= 2'd0;
          err_q   <= 1'b0;
        end else begin
          phase_q <= phase_d;
          mpos_q  <= mpos_d;
          cand_q  <= cand_d;
          cur_q   <= cur_d;
          pres_q  <= pres_d;
          put_q   <= put_d;
          len_q   <= len_d;
          track_q <= track_d;
          err_q   <= err_d;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q  <= request_byte_i;
      s1_final_q <= final_byte_i;
    end
    if (fire) begin
      byte_kind_o     <= kind;
      header_id_o     <= hid;
      data_byte_o     <= (kind != hrp_pkg::KIND_NONE) ? c : 8'd0;
      request_done_o  <= done;
      request_valid_o <= verdict;
      method_put_o    <= put_d;
      body_length_o   <= len_d;
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the HTTP request header parser byte by byte. A short directed table
// runs first, then whole random requests with faults, truncation and noise
// mixed in, over several required-mask settings. A predictor in this file
// tracks the parse state and checks every output beat, field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_ITEMS = 250;

  typedef enum logic [2:0] {
    ST_METHOD, ST_URL, ST_VERSION, ST_NAME, ST_SPACE, ST_VALUE, ST_LF, ST_ERROR
  } parse_st_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  hid;
    logic [7:0]  data;
    logic        done;
    logic        valid;
    logic        put;
    logic [31:0] clen;
  } tagged_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       fixed;
    tagged_t    want;
  } step_row_t;

  localparam tagged_t NO_TAG = '0;

  // Rows marked fixed carry their expected beat; the rest go to the predictor.
  localparam step_row_t DIRECTED [21] = '{
    '{"X", 1'b1, 1'b1,
      '{hrp_pkg::KIND_NONE, hrp_pkg::ID_OTHER, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0}},
    '{"P", 1'b0, 1'b0, NO_TAG},
    '{"U", 1'b0, 1'b0, NO_TAG},
    '{"T", 1'b0, 1'b0, NO_TAG},
    '{" ", 1'b0, 1'b0, NO_TAG},
    '{8'hFF, 1'b0, 1'b1,
      '{hrp_pkg::KIND_URL, hrp_pkg::ID_OTHER, 8'hFF, 1'b0, 1'b0, 1'b1, 32'd0}},
    '{8'h00, 1'b0, 1'b1,
      '{hrp_pkg::KIND_URL, hrp_pkg::ID_OTHER, 8'h00, 1'b0, 1'b0, 1'b1, 32'd0}},
    '{" ", 1'b0, 1'b0, NO_TAG},
    '{"H", 1'b0, 1'b0, NO_TAG},
    '{"T", 1'b0, 1'b0, NO_TAG},
    '{"T", 1'b0, 1'b0, NO_TAG},
    '{"P", 1'b0, 1'b0, NO_TAG},
    '{"/", 1'b0, 1'b0, NO_TAG},
    '{"1", 1'b0, 1'b0, NO_TAG},
    '{".", 1'b0, 1'b0, NO_TAG},
    '{"1", 1'b0, 1'b0, NO_TAG},
    '{hrp_pkg::CH_CR, 1'b0, 1'b0, NO_TAG},
    '{hrp_pkg::CH_LF, 1'b0, 1'b0, NO_TAG},
    '{hrp_pkg::CH_CR, 1'b0, 1'b0, NO_TAG},
    '{hrp_pkg::CH_LF, 1'b0, 1'b1,
      '{hrp_pkg::KIND_NONE, hrp_pkg::ID_OTHER, 8'h00, 1'b1, 1'b0, 1'b1, 32'd0}},
    '{"G", 1'b1, 1'b1,
      '{hrp_pkg::KIND_NONE, hrp_pkg::ID_OTHER, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0}}
  };

  string hdr_names [9] = '{
    "Host", "Connection", "Date", "Accept", "Accept-Language",
    "If-Modified-Since", "Content-Language", "Content-Type", "Content-Length"
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  request_byte_i = '0;
  logic        final_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  byte_kind_o;
  logic [3:0]  header_id_o;
  logic [7:0]  data_byte_o;
  logic        request_done_o;
  logic        request_valid_o;
  logic        method_put_o;
  logic [31:0] body_length_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = hrp_pkg::CFG_GET_MASK;
  logic [8:0]  cfg_data_i = '0;

  http_request_header_parser dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state.
  parse_st_e          ph;
  logic [4:0]         mpos;
  hrp_pkg::hdr_mask_t cand;
  logic [3:0]         cur_hdr;
  hrp_pkg::hdr_mask_t present;
  logic               put_f;
  logic [31:0]        clen;
  logic [1:0]         crlf_seen;
  logic               err;
  hrp_pkg::hdr_mask_t get_mask = hrp_pkg::GET_MASK_RST;
  hrp_pkg::hdr_mask_t put_mask = hrp_pkg::PUT_MASK_RST;

  tagged_t     pending_tags [$];
  logic [7:0]  req_text [$];
  bit          req_faulty;
  bit          steady;
  int unsigned counted;
  int unsigned mismatches;
  int unsigned cycles;

  function automatic void clear_parse();
    ph = ST_METHOD;
    mpos = '0;
    cand = hrp_pkg::ALL_NAMES;
    cur_hdr = hrp_pkg::ID_OTHER;
    present = '0;
    put_f = 1'b0;
    clen = '0;
    crlf_seen = '0;
    err = 1'b0;
  endfunction

  function automatic void go_error();
    err = 1'b1;
    ph = ST_ERROR;
  endfunction

  function automatic logic need_met();
    hrp_pkg::hdr_mask_t need;
    need = put_f ? put_mask : get_mask;
    return (present & need) == need;
  endfunction

  function automatic logic [3:0] resolve_hdr();
    hrp_pkg::hdr_mask_t allow;
    allow = put_f ? (hrp_pkg::ALL_NAMES & ~hrp_pkg::GET_ONLY)
                  : (hrp_pkg::ALL_NAMES & ~hrp_pkg::PUT_ONLY);
    for (int i = 0; i < 9; i++) begin
      if ((cand[i] & allow[i]) && hdr_names[i].len() == int'(mpos)) return 4'(i);
    end
    return hrp_pkg::ID_OTHER;
  endfunction

  function automatic tagged_t parse_byte(logic [7:0] c, logic fin);
    tagged_t    res;
    logic [1:0] old_track;
    logic [63:0] grown;
    res = '0;
    res.hid = hrp_pkg::ID_OTHER;
    old_track = crlf_seen;
    if (c == hrp_pkg::CH_CR) crlf_seen = (old_track == 2'd2) ? 2'd3 : 2'd1;
    else if (c == hrp_pkg::CH_LF) crlf_seen = (old_track == 2'd1) ? 2'd2 : 2'd0;
    else crlf_seen = 2'd0;

    case (ph)
      ST_METHOD: begin
        if (c == hrp_pkg::CH_SP) begin
          if (mpos == 5'd3 && cand[1:0] != 2'b00) begin
            put_f = cand[1];
            cand = hrp_pkg::ALL_NAMES;
            mpos = '0;
            ph = ST_URL;
          end else begin
            go_error();
          end
        end else if (mpos >= 5'd3) begin
          go_error();
        end else begin
          if (c != hrp_pkg::VERB_GET[23 - 8*mpos -: 8]) cand[0] = 1'b0;
          if (c != hrp_pkg::VERB_PUT[23 - 8*mpos -: 8]) cand[1] = 1'b0;
          if (cand[1:0] == 2'b00) go_error();
          else mpos++;
        end
      end
      ST_URL: begin
        if (c == hrp_pkg::CH_SP) begin
          mpos = '0;
          ph = ST_VERSION;
        end else if (c == hrp_pkg::CH_CR || c == hrp_pkg::CH_LF) begin
          go_error();
        end else begin
          res.kind = hrp_pkg::KIND_URL;
        end
      end
      ST_VERSION: begin
        if (mpos < 5'd8) begin
          if (c == hrp_pkg::PROTO_TEXT[63 - 8*mpos -: 8]) mpos++;
          else go_error();
        end else if (c == hrp_pkg::CH_CR) begin
          ph = ST_LF;
        end else begin
          go_error();
        end
      end
      ST_NAME: begin
        if (mpos == 5'd0 && c == hrp_pkg::CH_CR) begin
          ph = ST_LF;
        end else if (c == hrp_pkg::CH_COLON) begin
          cur_hdr = resolve_hdr();
          ph = ST_SPACE;
        end else if (c == hrp_pkg::CH_CR || c == hrp_pkg::CH_LF) begin
          go_error();
        end else begin
          for (int i = 0; i < 9; i++) begin
            if (int'(mpos) >= hdr_names[i].len() || hdr_names[i][mpos] != c) cand[i] = 1'b0;
          end
          if (mpos < 5'd31) mpos++;
        end
      end
      ST_SPACE: begin
        if (c == hrp_pkg::CH_SP) begin
          if (cur_hdr < 4'd9) present[cur_hdr] = 1'b0;
          if (cur_hdr == hrp_pkg::ID_CLEN) clen = '0;
          mpos = '0;
          ph = ST_VALUE;
        end else begin
          go_error();
        end
      end
      ST_VALUE: begin
        if (c == hrp_pkg::CH_CR) begin
          ph = ST_LF;
        end else if (c == hrp_pkg::CH_LF) begin
          go_error();
        end else begin
          res.kind = hrp_pkg::KIND_VALUE;
          res.hid = cur_hdr;
          if (cur_hdr < 4'd9) present[cur_hdr] = 1'b1;
          // Digits count only until the first non-digit of the value.
          if (cur_hdr == hrp_pkg::ID_CLEN && mpos == 5'd0) begin
            if (c >= hrp_pkg::CH_ZERO && c <= hrp_pkg::CH_NINE) begin
              grown = 64'(clen) * 64'd10 + 64'(c - hrp_pkg::CH_ZERO);
              clen = (grown > 64'hFFFF_FFFF) ? '1 : grown[31:0];
            end else begin
              mpos = 5'd1;
            end
          end
        end
      end
      ST_LF: begin
        if (c == hrp_pkg::CH_LF) begin
          if (old_track == 2'd3) begin
            res.done = 1'b1;
            res.valid = err ? 1'b0 : need_met();
          end else begin
            mpos = '0;
            cand = hrp_pkg::ALL_NAMES;
            cur_hdr = hrp_pkg::ID_OTHER;
            ph = ST_NAME;
          end
        end else begin
          go_error();
        end
      end
      default: begin
        if (c == hrp_pkg::CH_LF && old_track == 2'd3) res.done = 1'b1;
      end
    endcase

    if (fin && !res.done) begin
      res.done = 1'b1;
      res.valid = (!err && ph >= ST_NAME && ph <= ST_LF) ? need_met() : 1'b0;
    end
    res.data = (res.kind != hrp_pkg::KIND_NONE) ? c : 8'h00;
    res.put = put_f;
    res.clen = clen;
    if (res.done) clear_parse();
    return res;
  endfunction

  initial clear_parse();

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic send_byte(logic [7:0] b, logic fin, logic fixed, tagged_t want);
    int unsigned gap;
    tagged_t     pred;
    @(negedge clk_i);
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    request_byte_i = b;
    final_byte_i = fin;
    do @(posedge clk_i); while (!in_ready_o);
    counted++;
    pred = parse_byte(b, fin);
    pending_tags.push_back(fixed ? want : pred);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_tags.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mask(logic idx, hrp_pkg::hdr_mask_t val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == hrp_pkg::CFG_GET_MASK) get_mask = val;
    else put_mask = val;
  endtask

  function automatic logic [7:0] letter();
    return 8'($urandom_range(0, 1) ? $urandom_range(65, 90) : $urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] value_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == hrp_pkg::CH_CR || b == hrp_pkg::CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] url_byte();
    logic [7:0] b;
    do b = value_byte(); while (b == hrp_pkg::CH_SP);
    return b;
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) req_text.push_back(s[i]);
  endtask

  task automatic add_digits(int unsigned n);
    repeat (n) req_text.push_back(8'($urandom_range(48, 57)));
  endtask

  // Ids 0-8 are known names (now and then misspelt), 9 random, 10 overlong,
  // 11 a known prefix, 12 arbitrary bytes.
  task automatic add_header(int unsigned id, bit filled);
    int unsigned r;
    int unsigned k;
    bit          exact_cl;
    string       nm;
    exact_cl = 1'b0;
    r = $urandom_range(0, 99);
    if (id < 9) begin
      nm = hdr_names[id];
      if (r < 85) begin
        exact_cl = (id == 8);
        add_text(nm);
      end else begin
        k = $urandom_range(0, 2);
        if (k == 0) add_text(nm.substr(0, nm.len() - 2));
        else if (k == 1) add_text({nm, "s"});
        else add_text({"x", nm.substr(1, nm.len() - 1)});
      end
    end else if (id == 9) begin
      repeat ($urandom_range(1, 8)) req_text.push_back(letter());
    end else if (id == 10) begin
      repeat ($urandom_range(32, 40)) req_text.push_back(letter());
    end else if (id == 11) begin
      k = $urandom_range(0, 8);
      add_text(hdr_names[k].substr(0, $urandom_range(0, hdr_names[k].len() - 2)));
    end else begin
      repeat ($urandom_range(1, 6)) req_text.push_back(value_byte());
    end

    if ($urandom_range(0, 99) < 2) req_faulty = 1'b1;
    else req_text.push_back(hrp_pkg::CH_COLON);
    if ($urandom_range(0, 99) < 3) begin
      req_text.push_back(letter());
      req_faulty = 1'b1;
    end else begin
      req_text.push_back(hrp_pkg::CH_SP);
    end

    if (exact_cl) begin
      r = $urandom_range(0, 99);
      if (r < 50) add_digits($urandom_range(1, 4));
      else if (r < 70) add_digits($urandom_range(9, 14));
      else if (r < 80) add_text($urandom_range(0, 1) ? "4294967295" : "4294967296");
      else if (r < 88 && !filled) r = 0;
      else if (r < 94) begin
        add_digits($urandom_range(1, 5));
        repeat ($urandom_range(1, 3)) req_text.push_back(value_byte());
      end else begin
        req_text.push_back(letter());
        add_digits($urandom_range(1, 3));
      end
    end else begin
      repeat (filled ? $urandom_range(1, 10) : $urandom_range(0, 10))
        req_text.push_back(value_byte());
    end
    if ($urandom_range(0, 99) < 3) begin
      req_text.push_back(hrp_pkg::CH_LF);
      req_faulty = 1'b1;
    end

    req_text.push_back(hrp_pkg::CH_CR);
    if ($urandom_range(0, 99) < 2) begin
      req_text.push_back(letter());
      req_faulty = 1'b1;
    end
    req_text.push_back(hrp_pkg::CH_LF);
  endtask

  task automatic build_request();
    int unsigned r;
    int unsigned ids [9];
    int unsigned j;
    int unsigned t;
    bit          complete;
    req_text.delete();
    req_faulty = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 45) add_text("GET");
    else if (r < 90) add_text("PUT");
    else begin
      repeat ($urandom_range(1, 4)) req_text.push_back(letter());
      req_faulty = 1'b1;
    end
    req_text.push_back(hrp_pkg::CH_SP);
    repeat ($urandom_range(0, 12)) req_text.push_back(url_byte());
    if ($urandom_range(0, 99) < 3) begin
      req_text.push_back($urandom_range(0, 1) ? hrp_pkg::CH_CR : hrp_pkg::CH_LF);
      req_faulty = 1'b1;
    end
    req_text.push_back(hrp_pkg::CH_SP);
    add_text("HTTP/1.1");
    r = $urandom_range(0, 99);
    if (r < 4) begin
      req_text[req_text.size() - 1 - $urandom_range(0, 7)] = letter();
      req_faulty = 1'b1;
    end else if (r < 6) begin
      req_text.push_back(letter());
      req_faulty = 1'b1;
    end
    req_text.push_back(hrp_pkg::CH_CR);
    req_text.push_back(hrp_pkg::CH_LF);

    // A complete request carries every known header, its name now and then misspelt, with a non-empty value.
    complete = ($urandom_range(0, 99) < 40);
    if (complete) begin
      for (int i = 0; i < 9; i++) ids[i] = i;
      for (int i = 8; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = ids[i];
        ids[i] = ids[j];
        ids[j] = t;
      end
      for (int i = 0; i < 9; i++) add_header(ids[i], 1'b1);
      repeat ($urandom_range(0, 2)) add_header($urandom_range(0, 12), 1'b0);
    end else begin
      repeat ($urandom_range(0, 6)) add_header($urandom_range(0, 12), 1'b0);
    end

    if ($urandom_range(0, 99) < 85) begin
      req_text.push_back(hrp_pkg::CH_CR);
      req_text.push_back(hrp_pkg::CH_LF);
    end else begin
      t = $urandom_range(1, req_text.size());
      while (req_text.size() > t) void'(req_text.pop_back());
      req_faulty = 1'b1;
    end
  endtask

  task automatic send_request();
    bit fin_last;
    fin_last = req_faulty || ($urandom_range(0, 9) == 0);
    foreach (req_text[i])
      send_byte(req_text[i], fin_last && (i == req_text.size() - 1), 1'b0, NO_TAG);
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].b, DIRECTED[i].fin, DIRECTED[i].fixed, DIRECTED[i].want);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        1: begin
          write_mask(hrp_pkg::CFG_GET_MASK, '0);
          write_mask(hrp_pkg::CFG_PUT_MASK, '0);
        end
        2: begin
          write_mask(hrp_pkg::CFG_GET_MASK, hrp_pkg::ALL_NAMES);
          write_mask(hrp_pkg::CFG_PUT_MASK, hrp_pkg::ALL_NAMES);
        end
        4: begin
          write_mask(hrp_pkg::CFG_GET_MASK, hrp_pkg::GET_MASK_RST);
          write_mask(hrp_pkg::CFG_PUT_MASK, hrp_pkg::PUT_MASK_RST);
        end
        3, 5: begin
          write_mask(hrp_pkg::CFG_GET_MASK, 9'($urandom_range(0, 511)));
          write_mask(hrp_pkg::CFG_PUT_MASK, 9'($urandom_range(0, 511)));
        end
        default: ;
      endcase
      steady = (phase == 2);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 8) begin
          repeat ($urandom_range(1, 10))
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, NO_TAG);
        end else begin
          build_request();
          send_request();
        end
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("http_request_header_parser test passed");
    end else begin
      $display("http_request_header_parser test failed");
    end
    $finish;
  end

  initial begin : out_side
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (gap_len() > 0) begin
        out_ready_i = 1'b0;
        repeat (gap_len()) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      repeat ($urandom_range(0, 20)) @(negedge clk_i);
    end
  end

  // Every accepted output beat is held against the oldest pending prediction.
  always @(posedge clk_i) begin : check_beats
    tagged_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tags.size() == 0) begin
        flag_mismatch("beat with nothing pending", {31'd0, out_valid_o}, 32'd0);
      end else begin
        want = pending_tags.pop_front();
        if (byte_kind_o !== want.kind)
          flag_mismatch("byte_kind", 32'(byte_kind_o), 32'(want.kind));
        if (header_id_o !== want.hid)
          flag_mismatch("header_id", 32'(header_id_o), 32'(want.hid));
        if (data_byte_o !== want.data)
          flag_mismatch("data_byte", 32'(data_byte_o), 32'(want.data));
        if (request_done_o !== want.done)
          flag_mismatch("request_done", 32'(request_done_o), 32'(want.done));
        if (request_valid_o !== want.valid)
          flag_mismatch("request_valid", 32'(request_valid_o), 32'(want.valid));
        if (method_put_o !== want.put)
          flag_mismatch("method_put", 32'(method_put_o), 32'(want.put));
        if (body_length_o !== want.clen)
          flag_mismatch("body_length", body_length_o, want.clen);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("http_request_header_parser test failed");
      $finish;
    end
  end

endmodule
